[rtl/pt_pkg.sv]
// Shared types and constants for the pulse tachometer.
`default_nettype none

package pt_pkg;

  // Default number of stored periods.
  localparam int unsigned RING_DEPTH_DEF = 10;
  // Depth of the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned RPM_W    = 26;
  // Sum width covers the deepest supported ring (64 periods of 32 bits).
  localparam int unsigned SUM_W    = 38;
  localparam int unsigned STEP_W   = 6;

  localparam logic [CFG_W-1:0] MIN_PERIOD_RST = 24'd2000;
  localparam logic [CFG_W-1:0] MAX_PERIOD_RST = 24'd200000;
  localparam logic [RPM_W-1:0] RPM_NUM        = 26'd60000000;

  // Configuration port.
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic [APB_AW-1:0] ADDR_MIN_PERIOD = 3'd0;
  localparam logic [APB_AW-1:0] ADDR_MAX_PERIOD = 3'd4;

  typedef struct packed {
    logic [31:0] now_us;
    logic        pin_level;
  } in_item_t;

  typedef struct packed {
    logic [RPM_W-1:0] rpm;
    logic             is_on;
    logic             led_level;
    logic [31:0]      glitch_count;
  } out_item_t;

  // One classified tick handed from the front part to the back part.
  typedef struct packed {
    logic             ring_full;
    logic [SUM_W-1:0] sum;
    logic             pin_level;
    logic             led_level;
    logic [31:0]      glitch_count;
  } job_t;

  typedef enum logic [1:0] {
    FS_IDLE = 2'b01,
    FS_EXEC = 2'b10
  } front_state_e;

  typedef enum logic [3:0] {
    BS_IDLE = 4'b0001,
    BS_MEAN = 4'b0010,
    BS_RATE = 4'b0100,
    BS_OUT  = 4'b1000
  } back_state_e;

endpackage

`default_nettype wire

[rtl/pt_front.sv]
// Front part: accepts ticks, tracks edges and keeps the period ring and its running sum.
`default_nettype none

module pt_front #(
  parameter int unsigned RingDepth = pt_pkg::RING_DEPTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire pt_pkg::in_item_t        in_data_i,
  input  wire logic [pt_pkg::CFG_W-1:0] min_period_i,
  input  wire logic [pt_pkg::CFG_W-1:0] max_period_i,
  input  wire logic                    q_full_i,
  output logic                         push_o,
  output pt_pkg::job_t                 job_o
);

  localparam int unsigned IdxW = (RingDepth > 1) ? $clog2(RingDepth) : 1;
  localparam int unsigned CntW = $clog2(RingDepth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(RingDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(RingDepth);

  pt_pkg::front_state_e state_q, state_d;

  logic [31:0]                   now_q;
  logic                          pin_q;
  logic                          level_q, level_d;
  logic [31:0]                   last_rise_q, last_rise_d;
  logic [31:0]                   glitch_q, glitch_d;
  logic [IdxW-1:0]               widx_q, widx_d;
  logic [RingDepth-1:0]          valid_q, valid_d;
  logic [pt_pkg::SUM_W-1:0]      sum_q, sum_d;
  logic [CntW-1:0]               nzcnt_q, nzcnt_d;
  logic                          slot0_q, slot0_d;
  logic [pt_pkg::PERIOD_W-1:0]   rd_q;
  logic [pt_pkg::PERIOD_W-1:0]   ring_mem [RingDepth];

  logic [31:0] elapsed;
  logic [31:0] old_val;
  logic        timeout, level_chg, glitch, record, exec;

  assign in_stall_o = (state_q != pt_pkg::FS_IDLE);
  assign exec       = (state_q == pt_pkg::FS_EXEC) && !q_full_i;

  assign elapsed   = now_q - last_rise_q;
  assign old_val   = valid_q[widx_q] ? rd_q : 32'd0;
  assign timeout   = slot0_q && (elapsed > {8'd0, max_period_i});
  assign level_chg = (pin_q != level_q);
  assign glitch    = level_chg && pin_q && (elapsed < {8'd0, min_period_i});
  assign record    = !timeout && level_chg && pin_q && !glitch;

  always_comb begin
    state_d     = state_q;
    level_d     = level_q;
    last_rise_d = last_rise_q;
    glitch_d    = glitch_q;
    widx_d      = widx_q;
    valid_d     = valid_q;
    sum_d       = sum_q;
    nzcnt_d     = nzcnt_q;
    slot0_d     = slot0_q;
    case (state_q)
      pt_pkg::FS_IDLE: begin
        if (in_valid_i) begin
          state_d = pt_pkg::FS_EXEC;
        end
      end
      pt_pkg::FS_EXEC: begin
        if (exec) begin
          state_d = pt_pkg::FS_IDLE;
          if (timeout) begin
            // Timeout empties every slot but keeps the write position.
            valid_d = '0;
            sum_d   = '0;
            nzcnt_d = '0;
            slot0_d = 1'b0;
          end else if (level_chg) begin
            level_d = pin_q;
            if (glitch) begin
              glitch_d = glitch_q + 32'd1;
            end
            if (record) begin
              last_rise_d     = now_q;
              valid_d[widx_q] = 1'b1;
              sum_d   = sum_q - pt_pkg::SUM_W'(old_val) + pt_pkg::SUM_W'(elapsed);
              nzcnt_d = nzcnt_q + CntW'(elapsed != 32'd0) - CntW'(old_val != 32'd0);
              if (widx_q == '0) begin
                slot0_d = (elapsed != 32'd0);
              end
              widx_d = (widx_q == LastIdx) ? '0 : widx_q + IdxW'(1);
            end
          end
        end
      end
      default: state_d = pt_pkg::FS_IDLE;
    endcase
  end

  assign push_o             = exec;
  assign job_o.ring_full    = (nzcnt_d == FullCnt);
  assign job_o.sum          = sum_d;
  assign job_o.pin_level    = pin_q;
  assign job_o.led_level    = level_d;
  assign job_o.glitch_count = glitch_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pt_pkg::FS_IDLE;
      level_q     <= 1'b0;
      last_rise_q <= '0;
      glitch_q    <= '0;
      widx_q      <= '0;
      valid_q     <= '0;
      sum_q       <= '0;
      nzcnt_q     <= '0;
      slot0_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      last_rise_q <= last_rise_d;
      glitch_q    <= glitch_d;
      widx_q      <= widx_d;
      valid_q     <= valid_d;
      sum_q       <= sum_d;
      nzcnt_q     <= nzcnt_d;
      slot0_q     <= slot0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == pt_pkg::FS_IDLE) && in_valid_i) begin
      now_q <= in_data_i.now_us;
      pin_q <= in_data_i.pin_level;
    end
  end

  // The ring slot about to be overwritten is read ahead while the tick is captured.
  always_ff @(posedge clk_i) begin
    if (exec && record) begin
      ring_mem[widx_q] <= elapsed;
    end
    rd_q <= ring_mem[widx_q];
  end

endmodule

`default_nettype wire

[rtl/pt_queue.sv]
// Small queue of classified ticks between the front and back parts.
`default_nettype none

module pt_queue #(
  parameter int unsigned Depth = pt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire pt_pkg::job_t push_data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              empty_o,
  output pt_pkg::job_t      pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  pt_pkg::job_t entries_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == FullCnt);
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = entries_q[rptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/pt_back.sv]
// Back part: reciprocal multiply for the mean period, serial divider for the rpm, output register.
`default_nettype none

module pt_back #(
  parameter int unsigned RingDepth = pt_pkg::RING_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_empty_i,
  input  wire pt_pkg::job_t  job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output pt_pkg::out_item_t  out_data_o
);

  localparam int unsigned SumW  = pt_pkg::SUM_W;
  localparam int unsigned StepW = pt_pkg::STEP_W;
  // The mean period is the sum times a rounded-up reciprocal of the depth. With the shift set
  // to the sum width plus the ceiling log2 of the depth, the product gives the exact floor for
  // every sum that fits the sum width.
  localparam int unsigned LogDepth = (RingDepth > 1) ? $clog2(RingDepth) : 0;
  localparam int unsigned RecShift = SumW + LogDepth;
  localparam int unsigned ChunkW   = 13;
  localparam int unsigned Chunks   = (SumW + ChunkW) / ChunkW;
  localparam int unsigned RecW     = Chunks * ChunkW;
  localparam int unsigned PartW    = SumW + ChunkW;
  localparam int unsigned ProdW    = SumW + RecW;
  localparam logic [63:0] RecipFull =
    ((64'd1 << RecShift) + 64'(RingDepth) - 64'd1) / 64'(RingDepth);
  localparam logic [RecW-1:0]  Recip     = RecipFull[RecW-1:0];
  localparam logic [StepW-1:0] MeanSteps = StepW'(Chunks - 1);
  localparam logic [StepW-1:0] RateSteps = StepW'(pt_pkg::RPM_W - 1);

  pt_pkg::back_state_e state_q, state_d;

  pt_pkg::job_t            job_q;
  logic [SumW-1:0]         num_q, num_d;
  logic [31:0]             rem_q, rem_d;
  logic [31:0]             den_q, den_d;
  logic [StepW-1:0]        step_q, step_d;
  logic [pt_pkg::RPM_W-1:0] rpm_q, rpm_d;
  logic [ProdW-1:0]        acc_q, acc_d;
  logic [RecW-1:0]         rec_q, rec_d;
  logic                    out_valid_q;
  pt_pkg::out_item_t       out_q;

  logic [32:0]     rem_shift;
  logic            qbit;
  logic [SumW-1:0] num_step;
  logic [31:0]     rem_step;
  logic [PartW-1:0] part_prod;
  logic [ProdW-1:0] acc_step;
  logic [31:0]     mean;
  logic            out_free, load_out;

  // One restoring division step per cycle.
  assign rem_shift = {rem_q, num_q[SumW-1]};
  assign qbit      = (rem_shift >= {1'b0, den_q});
  assign rem_step  = qbit ? 32'(rem_shift - {1'b0, den_q}) : rem_shift[31:0];
  assign num_step  = {num_q[SumW-2:0], qbit};

  // One reciprocal chunk per cycle, most significant chunk first.
  assign part_prod = {{ChunkW{1'b0}}, num_q} * {{SumW{1'b0}}, rec_q[RecW-1 -: ChunkW]};
  assign acc_step  = {acc_q[ProdW-ChunkW-1:0], {ChunkW{1'b0}}} +
                     {{(ProdW - PartW){1'b0}}, part_prod};
  assign mean      = acc_step[RecShift +: 32];

  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == pt_pkg::BS_OUT) && out_free;
  assign pop_o    = (state_q == pt_pkg::BS_IDLE) && !q_empty_i;

  always_comb begin
    state_d = state_q;
    num_d   = num_q;
    rem_d   = rem_q;
    den_d   = den_q;
    step_d  = step_q;
    rpm_d   = rpm_q;
    acc_d   = acc_q;
    rec_d   = rec_q;
    case (state_q)
      pt_pkg::BS_IDLE: begin
        if (!q_empty_i) begin
          num_d  = job_i.sum;
          acc_d  = '0;
          rec_d  = Recip;
          step_d = MeanSteps;
          rpm_d  = '0;
          state_d = job_i.ring_full ? pt_pkg::BS_MEAN : pt_pkg::BS_OUT;
        end
      end
      pt_pkg::BS_MEAN: begin
        acc_d  = acc_step;
        rec_d  = {rec_q[RecW-ChunkW-1:0], {ChunkW{1'b0}}};
        step_d = step_q - StepW'(1);
        if (step_q == '0) begin
          if (mean == 32'd0) begin
            state_d = pt_pkg::BS_OUT;
          end else begin
            // Numerator is left aligned so its bits come out first.
            num_d   = {pt_pkg::RPM_NUM, {(SumW - pt_pkg::RPM_W){1'b0}}};
            rem_d   = '0;
            den_d   = mean;
            step_d  = RateSteps;
            state_d = pt_pkg::BS_RATE;
          end
        end
      end
      pt_pkg::BS_RATE: begin
        num_d  = num_step;
        rem_d  = rem_step;
        step_d = step_q - StepW'(1);
        if (step_q == '0) begin
          rpm_d   = num_step[pt_pkg::RPM_W-1:0];
          state_d = pt_pkg::BS_OUT;
        end
      end
      pt_pkg::BS_OUT: begin
        if (out_free) begin
          state_d = pt_pkg::BS_IDLE;
        end
      end
      default: state_d = pt_pkg::BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pt_pkg::BS_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= (out_valid_q && out_stall_i) || load_out;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    rpm_q <= rpm_d;
    acc_q <= acc_d;
    rec_q <= rec_d;
    if (pop_o) begin
      job_q <= job_i;
    end
    if (load_out) begin
      out_q.rpm          <= rpm_q;
      out_q.is_on        <= (rpm_q != '0) || !job_q.pin_level;
      out_q.led_level    <= job_q.led_level;
      out_q.glitch_count <= job_q.glitch_count;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[rtl/pulse_tachometer_rpm_top.sv]
// Top level of the pulse tachometer: configuration registers and the front, queue and back parts.
// A tick with a full ring passes through capture, classify and push, pop, 3 multiply steps for the mean
// period, 26 divide steps for the rpm and the output load; when a slot is empty, the back part skips
// the arithmetic. The front part takes a new tick only after it has pushed the last one into the queue,
// which waits while the queue is full; with a full ring the back part limits the tick rate.
// Reset is asynchronous and active low; it empties the period ring through valid bits at once,
// so no clearing pass is needed, and loads the period limits with 2000 and 200000 microseconds.
`default_nettype none

module pulse_tachometer_rpm_top #(
  parameter int unsigned RingDepth  = pt_pkg::RING_DEPTH_DEF,
  parameter int unsigned QueueDepth = pt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // Tick request channel.
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire pt_pkg::in_item_t          in_data_i,
  // Result request channel.
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output pt_pkg::out_item_t              out_data_o,
  // Configuration port.
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [pt_pkg::APB_AW-1:0] paddr,
  input  wire logic [pt_pkg::APB_DW-1:0] pwdata,
  output logic [pt_pkg::APB_DW-1:0]      prdata,
  output logic                           pready
);

  logic [pt_pkg::CFG_W-1:0] min_period_q;
  logic [pt_pkg::CFG_W-1:0] max_period_q;
  logic                     cfg_write;

  logic         push, q_full, pop, q_empty;
  pt_pkg::job_t push_job, pop_job;

  // Registers are written in the access phase; pready is tied high, so no wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_period_q <= pt_pkg::MIN_PERIOD_RST;
      max_period_q <= pt_pkg::MAX_PERIOD_RST;
    end else if (cfg_write) begin
      if (paddr == pt_pkg::ADDR_MIN_PERIOD) begin
        min_period_q <= pwdata[pt_pkg::CFG_W-1:0];
      end
      if (paddr == pt_pkg::ADDR_MAX_PERIOD) begin
        max_period_q <= pwdata[pt_pkg::CFG_W-1:0];
      end
    end
  end

  // Reads of unmapped addresses return zero.
  always_comb begin
    case (paddr)
      pt_pkg::ADDR_MIN_PERIOD: prdata = {8'd0, min_period_q};
      pt_pkg::ADDR_MAX_PERIOD: prdata = {8'd0, max_period_q};
      default:                 prdata = '0;
    endcase
  end

  // The front part classifies each tick and updates the edge state, the ring and its
  // running sum; what the back part needs travels through the queue as one job.
  pt_front #(
    .RingDepth(RingDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .min_period_i(min_period_q),
    .max_period_i(max_period_q),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  pt_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .pop_data_o (pop_job)
  );

  // The back part turns the ring sum into a mean period and then into rpm, and holds
  // the result in an output register so the next job can start while it waits.
  pt_back #(
    .RingDepth(RingDepth)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .job_i      (pop_job),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

[rtl/pt_checker.sv]
// Port-level checker for the pulse tachometer and its bind to the top level.
`default_nettype none

module pt_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_stall_o,
  input wire logic                      out_valid_o,
  input wire logic                      out_stall_i,
  input wire pt_pkg::out_item_t         out_data_o,
  input wire logic                      pready
);

  // A stalled result stays offered unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // A tick is worked on alone, so the input stalls right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // A nonzero rpm always reports the sensor as on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.rpm != '0) |-> out_data_o.is_on)
    else $error("rpm nonzero but not on");

  // The rpm never exceeds the numerator, reached only by a mean period of one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.rpm <= pt_pkg::RPM_NUM)
    else $error("rpm out of range");

  // The configuration port never inserts wait states.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind pulse_tachometer_rpm_top pt_checker u_pt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o),
  .pready     (pready)
);

`default_nettype wire

[test/testbench.sv]
// Testbench for the pulse tachometer: directed and random ticks checked against a local predictor.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned RING          = pt_pkg::RING_DEPTH_DEF;
  localparam logic [63:0] RPM_NUMERATOR = 64'd60000000;
  // Cycles without any accepted request before the run is declared hung. The longest
  // legal quiet stretch is the receiver hold plus one result latency.
  localparam int unsigned QUIET_LIMIT   = 5000;
  // Cycles to wait at the end for stray results.
  localparam int unsigned TAIL_CYCLES   = 100;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic              in_valid_i;
  logic              in_stall_o;
  pt_pkg::in_item_t  in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  pt_pkg::out_item_t out_data_o;

  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [pt_pkg::APB_AW-1:0] paddr;
  logic [pt_pkg::APB_DW-1:0] pwdata;
  logic [pt_pkg::APB_DW-1:0] prdata;
  logic                      pready;

  pulse_tachometer_rpm_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: the period limits and the tachometer's own bookkeeping.
  logic [23:0]  lim_min_us;
  logic [23:0]  lim_max_us;
  logic [31:0]  periods_us [RING];
  int unsigned  slot_ptr;
  logic         pin_seen;
  logic [31:0]  rise_stamp_us;
  logic [31:0]  glitch_tally;

  // Readings the block still owes, oldest first.
  pt_pkg::out_item_t pending_readings [$];
  pt_pkg::out_item_t want_reading;

  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;

  // Stimulus controls shared between the test tasks and the result sink.
  logic        in_idle_on = 1'b1;
  logic        out_idle_on = 1'b1;
  int unsigned hold_request = 0;
  // Timestamp of the last rising edge the stimulus planned; pulse trains build on it.
  logic [31:0] pulse_origin_us;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch: %s got %0d expected %0d at %0t ns", what, got, want, $time);
    error_count++;
  endtask

  // Advances the tachometer by one tick and returns the reading it must produce.
  function automatic pt_pkg::out_item_t tach_advance(input pt_pkg::in_item_t item);
    logic [31:0]       elapsed;
    logic [63:0]       total;
    logic [63:0]       mean;
    logic [63:0]       rate;
    logic              hole;
    pt_pkg::out_item_t reading;
    elapsed = item.now_us - rise_stamp_us;
    if (periods_us[0] != 32'd0 && elapsed > {8'd0, lim_max_us}) begin
      // No accepted rise for too long: the averaged periods are stale and dropped.
      for (int k = 0; k < RING; k++) periods_us[k] = 32'd0;
    end else if (item.pin_level != pin_seen) begin
      pin_seen = item.pin_level;
      if (item.pin_level) begin
        if (elapsed < {8'd0, lim_min_us}) begin
          glitch_tally = glitch_tally + 32'd1;
        end else begin
          rise_stamp_us = item.now_us;
          if (slot_ptr >= RING) slot_ptr = 0;
          periods_us[slot_ptr] = elapsed;
          slot_ptr = (slot_ptr >= RING - 1) ? 0 : slot_ptr + 1;
        end
      end
    end
    total = 64'd0;
    hole  = 1'b0;
    for (int k = 0; k < RING; k++) begin
      if (periods_us[k] == 32'd0) hole = 1'b1;
      total = total + {32'd0, periods_us[k]};
    end
    mean = total / RING;
    rate = (hole || mean == 64'd0) ? 64'd0 : RPM_NUMERATOR / mean;
    reading.rpm          = rate[pt_pkg::RPM_W-1:0];
    reading.is_on        = (rate != 64'd0) || !item.pin_level;
    reading.led_level    = pin_seen;
    reading.glitch_count = glitch_tally;
    return reading;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned dice;
    dice = $urandom_range(99);
    if (dice < 55) return 0;
    else if (dice < 92) return $urandom_range(4, 1);
    else return $urandom_range(60, 15);
  endfunction

  // Offers one tick and waits for the block to take it. Called and returns at a falling edge;
  // valid stays high afterwards so back-to-back ticks need no drop.
  task automatic send_tick(input logic [31:0] now_us, input logic pin_level);
    int unsigned      gap;
    pt_pkg::in_item_t item;
    item.now_us    = now_us;
    item.pin_level = pin_level;
    gap = in_idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i  = item;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_readings.push_back(tach_advance(item));
    @(negedge clk_i);
  endtask

  // One revolution of the sensor: a falling tick halfway, then the rising tick one period on.
  task automatic send_revolution(input logic [31:0] period_us);
    send_tick(pulse_origin_us + (period_us >> 1), 1'b0);
    send_tick(pulse_origin_us + period_us, 1'b1);
    pulse_origin_us = pulse_origin_us + period_us;
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (pending_readings.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [pt_pkg::APB_AW-1:0] addr,
                           input logic [pt_pkg::APB_DW-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == pt_pkg::ADDR_MIN_PERIOD) lim_min_us = data[23:0];
    else if (addr == pt_pkg::ADDR_MAX_PERIOD) lim_max_us = data[23:0];
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic apb_read_check(input logic [pt_pkg::APB_AW-1:0] addr);
    logic [pt_pkg::APB_DW-1:0] got;
    logic [pt_pkg::APB_DW-1:0] want;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    want = {8'd0, (addr == pt_pkg::ADDR_MIN_PERIOD) ? lim_min_us : lim_max_us};
    if (got !== want) report_mismatch("register readback", got, want);
  endtask

  // Limits change only with the block empty. The unused upper data bits carry noise,
  // which the block must ignore.
  task automatic program_limits(input logic [23:0] min_us, input logic [23:0] max_us);
    drain_results();
    apb_write(pt_pkg::ADDR_MIN_PERIOD, {8'($urandom), min_us});
    apb_write(pt_pkg::ADDR_MAX_PERIOD, {8'($urandom), max_us});
    apb_read_check(pt_pkg::ADDR_MIN_PERIOD);
    apb_read_check(pt_pkg::ADDR_MAX_PERIOD);
    pulse_origin_us = rise_stamp_us;
  endtask

  // Mostly clean pulse trains with random periods, mixed with glitches, timeouts,
  // ticks at arbitrary timestamps and ticks that repeat the current level.
  task automatic run_random(input int count, input logic [31:0] per_lo,
                            input logic [31:0] per_hi);
    int          done;
    int unsigned dice;
    logic [31:0] stamp;
    logic [31:0] offset;
    done = 0;
    while (done < count) begin
      dice = $urandom_range(99);
      if (dice < 72) begin
        send_revolution($urandom_range(per_hi, per_lo));
        done += 2;
      end else if (dice < 82) begin
        offset = (lim_min_us == 24'd0) ? 32'd0 : $urandom_range({8'd0, lim_min_us} - 1, 0);
        send_tick(pulse_origin_us + offset, 1'b0);
        send_tick(pulse_origin_us + offset, 1'b1);
        done += 2;
      end else if (dice < 90) begin
        stamp = pulse_origin_us + {8'd0, lim_max_us} + 32'd1 + $urandom_range(1000);
        send_tick(stamp, 1'($urandom_range(1)));
        pulse_origin_us = stamp - per_lo;
        done++;
      end else if (dice < 95) begin
        stamp = $urandom();
        send_tick(stamp, 1'($urandom_range(1)));
        pulse_origin_us = stamp;
        done++;
      end else begin
        send_tick(pulse_origin_us + $urandom_range(per_lo), pin_seen);
        done++;
      end
    end
  endtask

  task automatic test_register_defaults();
    apb_read_check(pt_pkg::ADDR_MIN_PERIOD);
    apb_read_check(pt_pkg::ADDR_MAX_PERIOD);
  endtask

  // Starts from reset: level low, no rise seen, empty ring, default limits.
  task automatic test_edge_cases();
    send_tick(32'd0, 1'b0);              // same level as after reset
    send_tick(32'd1000, 1'b1);           // rise too soon after time zero: a glitch
    send_tick(32'd1500, 1'b1);           // level unchanged
    send_tick(32'd1600, 1'b0);           // falling edge
    send_tick(32'd5000, 1'b1);           // first accepted period
    send_tick(32'd6000, 1'b0);
    send_tick(32'd305000, 1'b1);         // past the timeout: ring cleared, rise ignored
    send_tick(32'd305001, 1'b1);         // ring empty now, so the rise is taken
  endtask

  // Timestamps crossing the 32-bit wrap must still give the short elapsed time.
  task automatic test_wraparound();
    send_tick(32'hFFFF_F000, 1'b0);
    send_tick(32'hFFFF_F400, 1'b0);
    send_tick(32'hFFFF_F800, 1'b1);
    send_tick(32'hFFFF_FC00, 1'b0);
    send_tick(32'h0000_1000, 1'b1);
  endtask

  // With no lower limit, a rise at the same timestamp stores a zero period,
  // which then reads as an empty slot.
  task automatic test_zero_period();
    logic [31:0] stamp;
    program_limits(24'd0, 24'd200000);
    stamp = rise_stamp_us + 32'd10;
    send_tick(stamp, 1'b0);
    send_tick(stamp, 1'b1);
    send_tick(stamp, 1'b0);
    send_tick(stamp, 1'b1);
  endtask

  task automatic test_random_phases();
    program_limits(24'd2000, 24'd200000);
    run_random(550, 2000, 200000);
    program_limits(24'd0, 24'hFFFFFF);
    run_random(250, 0, 50);
    // Shortest periods without idling: a full ring of one-microsecond periods gives the
    // highest rate the block can report.
    program_limits(24'd1, 24'd16);
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    repeat (12) send_revolution(32'd1);
    run_random(200, 1, 1);
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    program_limits(24'hFFFFFF, 24'hFFFFFF);
    run_random(150, 32'hFFFFFF, 32'hFFFFFF);
    program_limits(24'd0, 24'd0);
    run_random(100, 0, 2);
    program_limits(24'd5000, 24'd60000);
    run_random(350, 3000, 70000);
  endtask

  // The receiver stops for a long stretch while ticks keep coming back to back,
  // so the internal queue fills and the tick channel must stall.
  task automatic test_output_backpressure();
    in_idle_on   = 1'b0;
    hold_request = 400;
    repeat (20) send_revolution(32'd20000);
    in_idle_on = 1'b1;
    run_random(60, 3000, 70000);
  endtask

  // Short bursts, each followed by a pause until every reading has come back.
  task automatic test_sender_pause();
    logic [23:0] lo;
    logic [23:0] hi;
    lo = 24'($urandom_range(5000, 100));
    hi = 24'($urandom_range(300000, 50000));
    program_limits(lo, hi);
    repeat (6) begin
      run_random(25, 500, 150000);
      drain_results();
    end
  endtask

  // Result sink: random stalls, plus a long hold when a test asks for one.
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned stall_left;
    hold_left   = 0;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else if (stall_left != 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else begin
        out_stall_i = 1'b0;
        if (out_idle_on && $urandom_range(3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Every reading taken from the block is matched against the oldest one still owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("reading with none pending, rpm", out_data_o.rpm, 0);
      end else begin
        want_reading = pending_readings.pop_front();
        if (out_data_o.rpm !== want_reading.rpm)
          report_mismatch("rpm", out_data_o.rpm, want_reading.rpm);
        if (out_data_o.is_on !== want_reading.is_on)
          report_mismatch("is_on", out_data_o.is_on, want_reading.is_on);
        if (out_data_o.led_level !== want_reading.led_level)
          report_mismatch("led_level", out_data_o.led_level, want_reading.led_level);
        if (out_data_o.glitch_count !== want_reading.glitch_count)
          report_mismatch("glitch_count", out_data_o.glitch_count, want_reading.glitch_count);
      end
    end
  end

  // Watchdog: any accepted request or register access counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;

    // Predictor state after reset.
    lim_min_us    = 24'd2000;
    lim_max_us    = 24'd200000;
    slot_ptr      = 0;
    pin_seen      = 1'b0;
    rise_stamp_us = 32'd0;
    glitch_tally  = 32'd0;
    for (int k = 0; k < RING; k++) periods_us[k] = 32'd0;
    pulse_origin_us = 32'd0;

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_register_defaults();
    test_edge_cases();
    test_wraparound();
    test_zero_period();
    test_random_phases();
    test_output_backpressure();
    test_sender_pause();

    // Everything owed has arrived; give the block time to show any reading it should not make.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
